/* rtl/cscr_pkg.sv */
// Package for the clocked serial cell receiver: register indexes, end reasons,
// configuration and result structs. No dependencies.
`default_nettype none

package cscr_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_LENGTH      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_TIMEOUT_MS = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BYTE_TIMEOUT_MS  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ABORT_ON_RELEASE = 8'd3;

    // register reset values
    localparam logic [7:0]  CELL_LENGTH_RST      = 8'd255;
    localparam logic [15:0] FIRST_TIMEOUT_MS_RST = 16'd5000;
    localparam logic [15:0] BYTE_TIMEOUT_MS_RST  = 16'd100;

    // end reasons
    localparam logic [1:0] REASON_LENGTH  = 2'd0;
    localparam logic [1:0] REASON_TIMEOUT = 2'd1;
    localparam logic [1:0] REASON_RELEASE = 2'd2;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef struct packed {
        logic [7:0]  cell_length;
        logic [15:0] first_timeout_ms;
        logic [15:0] byte_timeout_ms;
        logic        abort_on_release;
    } cfg_t;

    typedef struct packed {
        logic        busy_res;
        logic [7:0]  bytes_received;
        logic [1:0]  end_reason;
        logic        cell_done;
        logic [7:0]  byte_value;
        logic        byte_valid;
    } res_t;

endpackage

`default_nettype wire

/* rtl/clocked_serial_cell_receiver.sv */
// Top level of the clocked serial cell receiver: configuration registers,
// receive core and output buffer. Depends on cscr_pkg, cscr_rx_core, cscr_out_buf.
//
// channel   direction  handshake            payload
// s_*       in         s_tvalid/s_tready    tuser command, tdata line levels
// m_*       out        m_tvalid/m_tready    tuser byte_valid, tlast cell_done, tdata
// cfg_*     in         cfg_wr_en            cfg_index, cfg_wdata
//
// one sample per clock while s_tready is high; the receive state updates at the
// input transfer and the result is registered in the output or skid stage.
// the skid stage keeps input ready while one result waits; ready drops only
// once two results are held. reset clears the state and loads register defaults.
`default_nettype none

module clocked_serial_cell_receiver
    import cscr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic                   s_tuser,   // command
    input  wire logic [7:0]             s_tdata,   // clock_level, data_level,
                                                   // release_level, ms_tick, zeros
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic                        m_tuser,   // byte_valid
    output logic                        m_tlast,   // cell_done
    output logic [23:0]                 m_tdata,   // byte_value[7:0], end_reason[9:8],
                                                   // bytes_received[17:10], busy_res[18]
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t cfg_reg;
    logic accept;
    res_t core_res;
    res_t buf_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_length      <= CELL_LENGTH_RST;
            cfg_reg.first_timeout_ms <= FIRST_TIMEOUT_MS_RST;
            cfg_reg.byte_timeout_ms  <= BYTE_TIMEOUT_MS_RST;
            cfg_reg.abort_on_release <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CELL_LENGTH:      cfg_reg.cell_length      <= cfg_wdata[7:0];
                REG_FIRST_TIMEOUT_MS: cfg_reg.first_timeout_ms <= cfg_wdata;
                REG_BYTE_TIMEOUT_MS:  cfg_reg.byte_timeout_ms  <= cfg_wdata;
                REG_ABORT_ON_RELEASE: cfg_reg.abort_on_release <= cfg_wdata[0];
                default:              ;
            endcase
        end
    end

    assign accept = s_tvalid && s_tready;

    cscr_rx_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .command       (s_tuser),
        .clock_level   (s_tdata[0]),
        .data_level    (s_tdata[1]),
        .release_level (s_tdata[2]),
        .ms_tick       (s_tdata[3]),
        .cfg           (cfg_reg),
        .res           (core_res)
    );

    cscr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_res    (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (buf_res)
    );

    assign m_tuser = buf_res.byte_valid;
    assign m_tlast = buf_res.cell_done;
    assign m_tdata = {5'd0, buf_res.busy_res, buf_res.bytes_received,
                      buf_res.end_reason, buf_res.byte_value};

endmodule

`default_nettype wire

/* rtl/cscr_rx_core.sv */
// Receive state and per-sample update of the cell receiver.
// Depends on cscr_pkg.
`default_nettype none

module cscr_rx_core
    import cscr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic accept,
    input  wire logic command,
    input  wire logic clock_level,
    input  wire logic data_level,
    input  wire logic release_level,
    input  wire logic ms_tick,
    input  wire cfg_t cfg,
    output res_t      res
);

    logic        receiving_reg,    receiving_next;
    logic        last_clock_reg,   last_clock_next;
    logic [7:0]  shift_byte_reg,   shift_byte_next;
    logic [2:0]  bit_counter_reg,  bit_counter_next;
    logic [7:0]  byte_counter_reg, byte_counter_next;
    logic [15:0] time_left_reg,    time_left_next;

    logic        bvalid;
    logic [7:0]  bval;
    logic        done;
    logic [1:0]  reason;
    logic        completed;
    logic [7:0]  shifted;
    logic [7:0]  count_inc;
    logic [15:0] time_dec;

    assign shifted   = {~data_level, shift_byte_reg[7:1]};
    assign count_inc = byte_counter_reg + 8'd1;
    assign time_dec  = time_left_reg - 16'd1;

    always_comb
    begin
        receiving_next    = receiving_reg;
        last_clock_next   = last_clock_reg;
        shift_byte_next   = shift_byte_reg;
        bit_counter_next  = bit_counter_reg;
        byte_counter_next = byte_counter_reg;
        time_left_next    = time_left_reg;
        bvalid            = 1'b0;
        bval              = 8'd0;
        done              = 1'b0;
        reason            = REASON_LENGTH;
        completed         = 1'b0;

        if (command)
        begin
            receiving_next    = 1'b1;
            last_clock_next   = 1'b0;
            shift_byte_next   = 8'd0;
            bit_counter_next  = 3'd0;
            byte_counter_next = 8'd0;
            time_left_next    = cfg.first_timeout_ms;
            if (cfg.cell_length == 8'd0)
            begin
                receiving_next = 1'b0;
                done           = 1'b1;
            end
        end
        else if (receiving_reg)
        begin
            if (cfg.abort_on_release && release_level)
            begin
                receiving_next = 1'b0;
                done           = 1'b1;
                reason         = REASON_RELEASE;
            end
            else if (time_left_reg == 16'd0)
            begin
                receiving_next = 1'b0;
                done           = 1'b1;
                reason         = REASON_TIMEOUT;
            end
            else
            begin
                if (clock_level != last_clock_reg)
                begin
                    last_clock_next = clock_level;
                    // falling edge of the line clock
                    if (!clock_level)
                    begin
                        shift_byte_next = shifted;
                        if (bit_counter_reg == LAST_BIT)
                        begin
                            bit_counter_next  = 3'd0;
                            bvalid            = 1'b1;
                            bval              = shifted;
                            byte_counter_next = count_inc;
                            time_left_next    = cfg.byte_timeout_ms;
                            completed         = 1'b1;
                            if (count_inc >= cfg.cell_length)
                            begin
                                receiving_next = 1'b0;
                                done           = 1'b1;
                            end
                        end
                        else
                        begin
                            bit_counter_next = bit_counter_reg + 3'd1;
                        end
                    end
                end
                // a completed byte reloads the timeout, the tick is dropped
                if (!completed && ms_tick)
                begin
                    time_left_next = time_dec;
                    if (time_dec == 16'd0)
                    begin
                        receiving_next = 1'b0;
                        done           = 1'b1;
                        reason         = REASON_TIMEOUT;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg    <= 1'b0;
            last_clock_reg   <= 1'b0;
            shift_byte_reg   <= 8'd0;
            bit_counter_reg  <= 3'd0;
            byte_counter_reg <= 8'd0;
            time_left_reg    <= 16'd0;
        end
        else if (accept)
        begin
            receiving_reg    <= receiving_next;
            last_clock_reg   <= last_clock_next;
            shift_byte_reg   <= shift_byte_next;
            bit_counter_reg  <= bit_counter_next;
            byte_counter_reg <= byte_counter_next;
            time_left_reg    <= time_left_next;
        end
    end

    always_comb
    begin
        res.byte_valid     = bvalid;
        res.byte_value     = bval;
        res.cell_done      = done;
        res.end_reason     = reason;
        res.bytes_received = byte_counter_next;
        res.busy_res       = receiving_next;
    end

endmodule

`default_nettype wire

/* rtl/cscr_out_buf.sv */
// Output register with a skid stage for result items of the cell receiver.
// Depends on cscr_pkg.
`default_nettype none

module cscr_out_buf
    import cscr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire res_t in_res,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_res
);

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_res_reg, out_res_next;
    res_t skid_res_reg, skid_res_next;
    logic in_xfer;

    assign in_ready  = !skid_valid_reg;
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                // skid drains first; no input transfer while it is full
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_xfer;
                if (in_xfer)
                begin
                    out_res_next = in_res;
                end
            end
        end
        else if (in_xfer)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = in_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

endmodule

`default_nettype wire

/* dv/clocked_serial_cell_receiver_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for clocked_serial_cell_receiver: streams line samples,
// predicts each result cycle-free and compares it field by field on the output.
// Depends on cscr_pkg and the receiver RTL.

module clocked_serial_cell_receiver_test;

    import cscr_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [7:0] DIRECTED_BYTE = 8'h96;

    typedef struct packed {
        logic command;
        logic clock_level;
        logic data_level;
        logic release_level;
        logic ms_tick;
    } line_sample_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic                   s_tuser = 1'b0;
    logic [7:0]             s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   m_tuser;
    logic                   m_tlast;
    logic [23:0]            m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // samples waiting to go out and results owed by the receiver
    line_sample_t line_samples[$];
    res_t         cell_results_due[$];
    line_sample_t cur_sample = '0;

    // shadow of the receiver: registers and line state
    cfg_t       rx_cfg = '{CELL_LENGTH_RST, FIRST_TIMEOUT_MS_RST, BYTE_TIMEOUT_MS_RST, 1'b0};
    logic       rx_active = 1'b0;
    logic       prev_clk = 1'b0;
    logic [7:0] shreg = '0;
    logic [2:0] bit_cnt = '0;
    logic [7:0] rx_count = '0;
    logic [15:0] ms_left = '0;

    int  mismatches = 0;
    int  generated = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  recv_stall = 0;
    int  hold_cycles = 0;
    bit  send_burst = 1'b0;
    bit  recv_burst = 1'b0;
    bit  offering;
    bit  take;

    clocked_serial_cell_receiver u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),   // command
        .s_tdata   (s_tdata),   // clock_level, data_level, release_level, ms_tick, zeros
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),   // byte_valid
        .m_tlast   (m_tlast),   // cell_done
        .m_tdata   (m_tdata),   // byte_value, end_reason, bytes_received, busy_res, zeros
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // expected result of one accepted sample, advancing the shadow state
    task automatic rx_predict_sample(input line_sample_t smp);
        res_t r;
        logic byte_done;
        r = '0;
        byte_done = 1'b0;
        if (smp.command)
        begin
            rx_active = 1'b1;
            prev_clk  = 1'b0;
            shreg     = '0;
            bit_cnt   = '0;
            rx_count  = '0;
            ms_left   = rx_cfg.first_timeout_ms;
            if (rx_cfg.cell_length == 8'd0)
            begin
                rx_active    = 1'b0;
                r.cell_done  = 1'b1;
                r.end_reason = REASON_LENGTH;
            end
        end
        else if (rx_active)
        begin
            if (rx_cfg.abort_on_release && smp.release_level)
            begin
                rx_active    = 1'b0;
                r.cell_done  = 1'b1;
                r.end_reason = REASON_RELEASE;
            end
            else if (ms_left == 16'd0)
            begin
                rx_active    = 1'b0;
                r.cell_done  = 1'b1;
                r.end_reason = REASON_TIMEOUT;
            end
            else
            begin
                if (smp.clock_level != prev_clk)
                begin
                    prev_clk = smp.clock_level;
                    if (!smp.clock_level)
                    begin
                        // falling edge: inverted data enters at the top, lsb first overall
                        shreg = {~smp.data_level, shreg[7:1]};
                        if (bit_cnt == LAST_BIT)
                        begin
                            bit_cnt      = '0;
                            r.byte_valid = 1'b1;
                            r.byte_value = shreg;
                            rx_count     = rx_count + 8'd1;
                            ms_left      = rx_cfg.byte_timeout_ms;
                            byte_done    = 1'b1;
                            if (rx_count >= rx_cfg.cell_length)
                            begin
                                rx_active    = 1'b0;
                                r.cell_done  = 1'b1;
                                r.end_reason = REASON_LENGTH;
                            end
                        end
                        else
                        begin
                            bit_cnt = bit_cnt + 3'd1;
                        end
                    end
                end
                // tick is dropped on the sample that completes a byte
                if (!byte_done && smp.ms_tick)
                begin
                    ms_left = ms_left - 16'd1;
                    if (ms_left == 16'd0)
                    begin
                        rx_active    = 1'b0;
                        r.cell_done  = 1'b1;
                        r.end_reason = REASON_TIMEOUT;
                    end
                end
            end
        end
        r.bytes_received = rx_count;
        r.busy_res       = rx_active;
        cell_results_due.push_back(r);
    endtask

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tuser  <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            offering = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                rx_predict_sample(cur_sample);
                offering = 1'b0;
                if ($urandom_range(0, 49) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 7);
            end
            if (!offering)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (line_samples.size() != 0)
                begin
                    cur_sample = line_samples.pop_front();
                    offering   = 1'b1;
                end
            end
            s_tvalid <= offering;
            s_tuser  <= cur_sample.command;
            s_tdata  <= {4'b0, cur_sample.ms_tick, cur_sample.release_level,
                         cur_sample.data_level, cur_sample.clock_level};
        end
    end

    // result monitor with random stalls and a few long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (cell_results_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected transfer, expected none actual %h", $time,
                             {m_tlast, m_tuser, m_tdata});
                end
                else
                begin
                    res_t want;
                    want = cell_results_due.pop_front();
                    compare_field("byte_valid", 8'(want.byte_valid), 8'(m_tuser));
                    compare_field("byte_value", want.byte_value, m_tdata[7:0]);
                    compare_field("cell_done", 8'(want.cell_done), 8'(m_tlast));
                    compare_field("end_reason", 8'(want.end_reason), 8'(m_tdata[9:8]));
                    compare_field("bytes_received", want.bytes_received, m_tdata[17:10]);
                    compare_field("busy_res", 8'(want.busy_res), 8'(m_tdata[18]));
                    compare_field("tdata padding", 8'd0, 8'(m_tdata[23:19]));
                end
                results_seen++;
                if (results_seen % 700 == 350)
                    hold_cycles = 120;
                if ($urandom_range(0, 49) == 0)
                    recv_burst = !recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 7);
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                take = 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                take = 1'b0;
            end
            else
            begin
                take = 1'b1;
            end
            m_tready <= take;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("clocked_serial_cell_receiver_test failed");
            $finish;
        end
    end

    task automatic add_sample(input logic cmd, input logic ck, input logic dat,
                              input logic rel, input logic tick);
        line_samples.push_back('{cmd, ck, dat, rel, tick});
        generated++;
    endtask

    // one byte on the line, lsb first, data low for a one bit
    task automatic add_byte(input logic [7:0] value, input int tick_pct, input int rel_pct,
                            output bit broken);
        int n_hi;
        int n_lo;
        broken = 1'b0;
        for (int b = 0; b < 8; b++)
        begin
            n_hi = $urandom_range(1, 3);
            n_lo = $urandom_range(1, 3);
            if ($urandom_range(0, 199) == 0)
            begin
                broken = 1'b1;
                return;
            end
            repeat (n_hi)
                add_sample(1'b0, 1'b1, 1'($urandom_range(0, 1)), chance(rel_pct),
                           chance(tick_pct));
            add_sample(1'b0, 1'b0, ~value[b], chance(rel_pct), chance(tick_pct));
            repeat (n_lo - 1)
                add_sample(1'b0, 1'b0, 1'($urandom_range(0, 1)), chance(rel_pct),
                           chance(tick_pct));
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (line_samples.size() != 0 || s_tvalid || cell_results_due.size() != 0);
        // settling margin after the last result
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_CELL_LENGTH:      rx_cfg.cell_length      = val[7:0];
            REG_FIRST_TIMEOUT_MS: rx_cfg.first_timeout_ms = val;
            REG_BYTE_TIMEOUT_MS:  rx_cfg.byte_timeout_ms  = val;
            REG_ABORT_ON_RELEASE: rx_cfg.abort_on_release = val[0];
            default: ;
        endcase
    endtask

    // upper data bits are junk on the narrow registers; one stray index is ignored
    task automatic program_receiver(input logic [7:0] len, input logic [15:0] first_ms,
                                    input logic [15:0] byte_ms, input logic abort_rel);
        write_reg(REG_CELL_LENGTH, {8'($urandom_range(0, 255)), len});
        write_reg(REG_FIRST_TIMEOUT_MS, first_ms);
        write_reg(8'($urandom_range(4, 255)), 16'($urandom_range(0, 65535)));
        write_reg(REG_BYTE_TIMEOUT_MS, byte_ms);
        write_reg(REG_ABORT_ON_RELEASE, {15'($urandom_range(0, 32767)), abort_rel});
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] pick_timeout();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'd1;
        if (r == 1)
            return 16'd65535;
        if (r == 2)
            return 16'd0;
        return 16'($urandom_range(2, 30));
    endfunction

    initial
    begin
        logic [7:0] len;
        int         tick_pct;
        int         rel_pct;
        int         phase_end;
        int         n_bytes;
        int         phase;
        bit         broken;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults: idle sample, start, one byte with release ignored
        add_sample(1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        add_sample(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        for (int b = 0; b < 8; b++)
        begin
            add_sample(1'b0, 1'b1, ~DIRECTED_BYTE[b], 1'b1, 1'b0);
            // tick on the completing sample must not count
            add_sample(1'b0, 1'b0, ~DIRECTED_BYTE[b], 1'b0, b == 7);
        end
        // restart in the middle of a cell
        add_sample(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        wait_drained();

        // zero cell length ends on the start itself
        program_receiver(8'd0, 16'd0, 16'd0, 1'b1);
        add_sample(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_sample(1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
        wait_drained();

        // zero first timeout expires on the next sample
        program_receiver(8'd1, 16'd0, 16'd65535, 1'b1);
        add_sample(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        wait_drained();

        // release wins over a tick on the same sample, then a tick timeout
        program_receiver(8'd3, 16'd1, 16'd1, 1'b1);
        add_sample(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_sample(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        add_sample(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_sample(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
        wait_drained();

        generated = 0;
        phase = 0;
        while (generated < RANDOM_ITEMS)
        begin
            case (phase)
                0: program_receiver(8'd255, 16'd65535, 16'd65535, 1'b0);
                1: program_receiver(8'd2, 16'd1, 16'd1, 1'b1);
                default:
                begin
                    case ($urandom_range(0, 9))
                        0: len = 8'd0;
                        1: len = 8'd255;
                        default: len = 8'($urandom_range(1, 6));
                    endcase
                    program_receiver(len, pick_timeout(), pick_timeout(),
                                     1'($urandom_range(0, 1)));
                end
            endcase
            tick_pct  = $urandom_range(0, 30);
            rel_pct   = $urandom_range(0, 5);
            phase_end = generated + $urandom_range(100, 200);
            while (generated < phase_end)
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        // line noise, now and then with stray start commands
                        repeat ($urandom_range(1, 8))
                            add_sample($urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)));
                    end
                    default:
                    begin
                        add_sample(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                        n_bytes = $urandom_range(1, 6);
                        for (int k = 0; k < n_bytes; k++)
                        begin
                            add_byte(8'($urandom_range(0, 255)), tick_pct, rel_pct, broken);
                            if (broken)
                                break;
                        end
                        repeat ($urandom_range(0, 3))
                            add_sample(1'b0, 1'b0, 1'($urandom_range(0, 1)),
                                       chance(rel_pct), chance(tick_pct));
                    end
                endcase
            end
            wait_drained();
            phase++;
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("clocked_serial_cell_receiver_test passed");
        else
            $display("clocked_serial_cell_receiver_test failed");
        $finish;
    end

endmodule
